/* rtl/kcl_pkg.sv */
// ----------------------------------------------------------------------------
// kcl_pkg: keypad code lock definitions
// Phase, key and indication codes, display patterns and the digit decoder
// for the lock controller, several of them also used by its checker.
// ----------------------------------------------------------------------------
package kcl_pkg;

    localparam int CODE_DIGITS_DEF = 2;

    localparam logic [7:0] CURSOR_PERIOD_RST = 8'd38;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_SET    = 2'd1,
        PH_VERIFY = 2'd2,
        PH_SPARE  = 2'd3
    } phase_t;

    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [3:0] KEY_STAR = 4'd10;
    localparam logic [3:0] KEY_HASH = 4'd11;
    localparam logic [3:0] KEY_MAX_DIGIT = 4'd9;

    localparam logic [2:0] IND_NONE          = 3'd0;
    localparam logic [2:0] IND_SET_REJECT    = 3'd1;
    localparam logic [2:0] IND_VERIFY_REJECT = 3'd2;
    localparam logic [2:0] IND_STORED        = 3'd3;
    localparam logic [2:0] IND_MATCH         = 3'd4;
    localparam logic [2:0] IND_MISMATCH      = 3'd5;

    localparam logic [6:0] SEG_DASH  = 7'h40;
    localparam logic [6:0] SEG_UNDER = 7'h08;
    localparam logic [6:0] SEG_BLANK = 7'h00;

    function automatic logic [6:0] digit_segs(input logic [3:0] d);
        logic [6:0] s;
        case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage

/* rtl/keypad_code_lock_controller.sv */
// ----------------------------------------------------------------------------
// keypad_code_lock_controller: two-display keypad code lock
// Takes decoded key presses and timer ticks, stores a code, checks attempts
// and returns the display patterns, an indication code and the lamp level.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (s_*): one request per key press or timer tick; s_command
//   selects which, s_key_code carries the key (ignored on a tick).
//   Result channel (m_*): exactly one result per request, in order.
//   Configuration: cfg_wr_en with cfg_wr_data writes cursor_period at once;
//   write it only while no request is in flight.
//   Latency: a result is valid the cycle after its request is accepted.
//   Throughput: one request per cycle while the receiver keeps m_ready high;
//   the whole state update is a single pass of logic from the state registers into the result register.
//   Stall: while the receiver holds m_ready low the result register holds
//   and s_ready drops; the request in it is taken as soon as m_ready rises,
//   and a new request is accepted in that same cycle.
//   Reset: aresetn (synchronous, active low) returns to idle with "--"
//   shown, an empty result register and cursor_period = 38.
// ----------------------------------------------------------------------------
module keypad_code_lock_controller #(
    parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_command,
    input  logic [3:0] s_key_code,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [6:0] m_left_segments,
    output logic [6:0] m_right_segments,
    output logic [2:0] m_indication,
    output logic       m_verify_led,
    output logic [1:0] m_phase_out
);

    localparam int POS_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(CODE_DIGITS - 1);

    // state
    logic [7:0]           cursor_period_reg;
    kcl_pkg::phase_t      phase_reg, phase_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [3:0]           code_reg [CODE_DIGITS];
    logic [3:0]           last_digit_reg, last_digit_next;
    logic                 mismatch_reg, mismatch_next;
    logic                 cursor_en_reg, cursor_en_next;
    logic                 cursor_vis_reg, cursor_vis_next;
    logic [7:0]           tick_count_reg, tick_count_next;
    logic                 lamp_reg, lamp_next;
    logic [6:0]           left_reg, left_next;
    logic [6:0]           right_reg, right_next;
    logic                 code_wr;
    logic [2:0]           ind_next;

    // result register
    logic                 m_valid_reg;
    logic [6:0]           m_left_reg, m_right_reg;
    logic [2:0]           m_ind_reg;
    logic                 m_lamp_reg;
    logic [1:0]           m_phase_reg;

    logic                 accept;
    logic                 is_digit;
    logic                 any_mismatch;
    logic [7:0]           tick_inc;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign is_digit     = (s_key_code <= kcl_pkg::KEY_MAX_DIGIT);
    assign any_mismatch = mismatch_reg || (code_reg[pos_reg] != s_key_code);
    assign tick_inc     = tick_count_reg + 8'd1;

    always_comb begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        last_digit_next = last_digit_reg;
        mismatch_next   = mismatch_reg;
        cursor_en_next  = cursor_en_reg;
        cursor_vis_next = cursor_vis_reg;
        tick_count_next = tick_count_reg;
        lamp_next       = lamp_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        code_wr         = 1'b0;
        ind_next        = kcl_pkg::IND_NONE;

        if (s_command == kcl_pkg::CMD_TICK) begin
            if (cursor_en_reg) begin
                tick_count_next = tick_inc;
                if (tick_inc >= cursor_period_reg) begin
                    tick_count_next = 8'd0;
                    left_next       = cursor_vis_reg ? kcl_pkg::SEG_UNDER : kcl_pkg::SEG_BLANK;
                    right_next      = left_next;
                    cursor_vis_next = !cursor_vis_reg;
                end
            end
        end else begin
            unique case (phase_reg)
                kcl_pkg::PH_SET, kcl_pkg::PH_VERIFY: begin
                    if (s_key_code == kcl_pkg::KEY_STAR || s_key_code == kcl_pkg::KEY_HASH) begin
                        if (phase_reg == kcl_pkg::PH_SET) begin
                            ind_next  = kcl_pkg::IND_SET_REJECT;
                            lamp_next = 1'b0;
                        end else begin
                            ind_next  = kcl_pkg::IND_VERIFY_REJECT;
                            lamp_next = 1'b1;
                        end
                    end else if (is_digit) begin
                        // show the previous digit left (a cursor on the first digit), the new one right
                        left_next  = (pos_reg == '0) ? kcl_pkg::SEG_UNDER
                                                     : kcl_pkg::digit_segs(last_digit_reg);
                        right_next = kcl_pkg::digit_segs(s_key_code);
                        if (pos_reg == '0) begin
                            cursor_en_next = 1'b0;
                        end
                        last_digit_next = s_key_code;
                        pos_next        = pos_reg + POS_W'(1);
                        if (phase_reg == kcl_pkg::PH_SET) begin
                            code_wr = 1'b1;
                            if (pos_reg == POS_LAST) begin
                                ind_next       = kcl_pkg::IND_STORED;
                                phase_next     = kcl_pkg::PH_VERIFY;
                                lamp_next      = 1'b1;
                                pos_next       = '0;
                                mismatch_next  = 1'b0;
                                cursor_en_next = 1'b1;
                                left_next      = kcl_pkg::SEG_UNDER;
                                right_next     = kcl_pkg::SEG_UNDER;
                            end
                        end else begin
                            mismatch_next = any_mismatch;
                            if (pos_reg == POS_LAST) begin
                                pos_next      = '0;
                                mismatch_next = 1'b0;
                                if (!any_mismatch) begin
                                    ind_next       = kcl_pkg::IND_MATCH;
                                    phase_next     = kcl_pkg::PH_IDLE;
                                    cursor_en_next = 1'b0;
                                    left_next      = kcl_pkg::SEG_DASH;
                                    right_next     = kcl_pkg::SEG_DASH;
                                end else begin
                                    ind_next       = kcl_pkg::IND_MISMATCH;
                                    lamp_next      = 1'b1;
                                    cursor_en_next = 1'b1;
                                    left_next      = kcl_pkg::SEG_UNDER;
                                    right_next     = kcl_pkg::SEG_UNDER;
                                end
                            end
                        end
                    end
                end
                default: begin
                    // idle: only star opens code entry
                    if (s_key_code == kcl_pkg::KEY_STAR) begin
                        phase_next     = kcl_pkg::PH_SET;
                        pos_next       = '0;
                        mismatch_next  = 1'b0;
                        cursor_en_next = 1'b1;
                        left_next      = kcl_pkg::SEG_UNDER;
                        right_next     = kcl_pkg::SEG_UNDER;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_period_reg <= kcl_pkg::CURSOR_PERIOD_RST;
            phase_reg         <= kcl_pkg::PH_IDLE;
            pos_reg           <= '0;
            last_digit_reg    <= 4'd0;
            mismatch_reg      <= 1'b0;
            cursor_en_reg     <= 1'b0;
            cursor_vis_reg    <= 1'b1;
            tick_count_reg    <= 8'd0;
            lamp_reg          <= 1'b0;
            left_reg          <= kcl_pkg::SEG_DASH;
            right_reg         <= kcl_pkg::SEG_DASH;
            m_valid_reg       <= 1'b0;
            for (int i = 0; i < CODE_DIGITS; i++) begin
                code_reg[i] <= 4'd0;
            end
        end else begin
            if (cfg_wr_en) begin
                cursor_period_reg <= cfg_wr_data;
            end
            if (accept) begin
                phase_reg      <= phase_next;
                pos_reg        <= pos_next;
                last_digit_reg <= last_digit_next;
                mismatch_reg   <= mismatch_next;
                cursor_en_reg  <= cursor_en_next;
                cursor_vis_reg <= cursor_vis_next;
                tick_count_reg <= tick_count_next;
                lamp_reg       <= lamp_next;
                left_reg       <= left_next;
                right_reg      <= right_next;
                if (code_wr) begin
                    code_reg[pos_reg] <= s_key_code;
                end
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload: load on accept, hold otherwise
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_left_reg  <= left_next;
            m_right_reg <= right_next;
            m_ind_reg   <= ind_next;
            m_lamp_reg  <= lamp_next;
            m_phase_reg <= (phase_next == kcl_pkg::PH_SPARE) ? 2'(kcl_pkg::PH_IDLE)
                                                             : 2'(phase_next);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_left_segments  = m_left_reg;
    assign m_right_segments = m_right_reg;
    assign m_indication     = m_ind_reg;
    assign m_verify_led     = m_lamp_reg;
    assign m_phase_out      = m_phase_reg;

endmodule

/* rtl/kcl_checker.sv */
// ----------------------------------------------------------------------------
// kcl_checker: port-level checks for the keypad code lock
// Watches the result channel of the lock controller; bound to that module.
// ----------------------------------------------------------------------------
module kcl_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [6:0] m_left_segments,
    input logic [6:0] m_right_segments,
    input logic [2:0] m_indication,
    input logic       m_verify_led,
    input logic [1:0] m_phase_out
);

    // hold a stalled result
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_left_segments)
            && $stable(m_right_segments) && $stable(m_indication)
            && $stable(m_verify_led) && $stable(m_phase_out))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stored code always moves to verifying with the lamp on
    a_stored: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_indication == kcl_pkg::IND_STORED
            |-> m_phase_out == 2'(kcl_pkg::PH_VERIFY) && m_verify_led)
        else $error("code stored without entering verify");

    a_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_indication == kcl_pkg::IND_MATCH
            |-> m_phase_out == 2'(kcl_pkg::PH_IDLE) && m_verify_led
                && m_left_segments == kcl_pkg::SEG_DASH
                && m_right_segments == kcl_pkg::SEG_DASH)
        else $error("match did not return to idle");

    a_set_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_indication == kcl_pkg::IND_SET_REJECT
            |-> m_phase_out == 2'(kcl_pkg::PH_SET) && !m_verify_led)
        else $error("set reject outside setting or with lamp on");

endmodule

bind keypad_code_lock_controller kcl_checker u_kcl_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_left_segments  (m_left_segments),
    .m_right_segments (m_right_segments),
    .m_indication     (m_indication),
    .m_verify_led     (m_verify_led),
    .m_phase_out      (m_phase_out)
);
